// ===== rtl/core/duplicate_packet_id_filter_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the duplicate packet ID filter
// Concurrent checks on the rising clock edge, off while reset is high.
// ---------------------------------------------------------------------------
`ifndef DUPLICATE_PACKET_ID_FILTER_ASSERT_SVH
`define DUPLICATE_PACKET_ID_FILTER_ASSERT_SVH

`ifndef ASSERT_OFF
// The property must hold at every clock edge outside reset.
`define DPF_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// The expression must never be true outside reset.
`define DPF_NEVER(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(expr)) else $error(msg);
`else
`define DPF_ASSERT(lbl, prop, msg)
`define DPF_NEVER(lbl, expr, msg)
`endif

`endif

// ===== rtl/core/dpf_pkg.sv =====
// ---------------------------------------------------------------------------
// dpf_pkg
// Sizes, command codes and the sequencer state type of the filter.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package dpf_pkg;

   localparam int WINDOW    = 50;
   localparam int CLIENTS   = 16;
   localparam int ID_W      = 20;
   localparam int SLOT_W    = 4;
   localparam int IDX_W     = $clog2(WINDOW);
   localparam int CNT_W     = $clog2(WINDOW + 1);
   localparam int RING_DEPTH = CLIENTS * WINDOW;
   localparam int ADDR_W    = $clog2(RING_DEPTH);

   localparam logic CMD_CHECK   = 1'b0;
   localparam logic CMD_RELEASE = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_WRITE,
      ST_RESPOND
   } state_type;

endpackage

// ===== rtl/core/dpf_ram.sv =====
// ---------------------------------------------------------------------------
// dpf_ram
// Generic RAM with one write port and one read port, read data registered.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module dpf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

// ===== rtl/core/duplicate_packet_id_filter.sv =====
// ---------------------------------------------------------------------------
// duplicate_packet_id_filter
// Per-client duplicate filter: each client slot keeps a ring of its last
// WINDOW packet IDs, searched one entry per cycle through a single RAM port.
// ---------------------------------------------------------------------------
//  channel   ports                                         direction
//  request   start, busy, req_cmd, req_client_slot,        in (busy out)
//            req_packet_id
//  response  rsp_valid, rsp_duplicate                      out
//
// A release or an out-of-range slot answers in the cycle after acceptance; the
// first check on an inactive slot passes through the write state and then the
// response state. A check on an active slot reads one ring entry per cycle from
// the shared RAM read port and compares it, then writes the new ID and responds;
// a match ends the search early and skips the write. Busy stays high until the
// response cycle is over. Reset clears pointers and slot flags; ring entries are
// tracked by pointer and a full flag, so no clearing pass.
// The response strobe lasts one cycle and cannot be stalled.
`timescale 1ns / 1ps

module duplicate_packet_id_filter
   import dpf_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic              req_cmd,
   input  logic [SLOT_W-1:0] req_client_slot,
   input  logic [ID_W-1:0]   req_packet_id,
   output logic              rsp_valid,
   output logic              rsp_duplicate
);

`include "duplicate_packet_id_filter_assert.svh"

   state_type state_ff, state_in;

   logic              cmd_ff;
   logic [SLOT_W-1:0] slot_ff;
   logic [ID_W-1:0]   id_ff;
   logic [ADDR_W-1:0] base_ff;
   logic [CNT_W-1:0]  k_ff, k_in;
   logic [CNT_W-1:0]  n_ff;
   logic              pend_ff, pend_in;
   logic              dup_ff;

   logic [IDX_W-1:0]  wp_ff     [CLIENTS];
   logic              full_ff   [CLIENTS];
   logic              active_ff [CLIENTS];

   logic              accept;
   logic              slot_bad;
   logic              match;
   logic              ram_we;
   logic [ADDR_W-1:0] ram_waddr;
   logic [ADDR_W-1:0] ram_raddr;
   logic [ID_W-1:0]   ram_rdata;

   assign accept   = start && (state_ff == ST_IDLE);
   assign slot_bad = int'(req_client_slot) >= CLIENTS;
   assign match    = pend_ff && (ram_rdata == id_ff);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (slot_bad || req_cmd == CMD_RELEASE) begin
                  state_in = ST_RESPOND;
               end else if (active_ff[req_client_slot]) begin
                  state_in = ST_SEARCH;
               end else begin
                  state_in = ST_WRITE;
               end
            end
         end
         ST_SEARCH: begin
            if (match) begin
               state_in = ST_RESPOND;
            end else if (k_ff == n_ff) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE:   state_in = ST_RESPOND;
         ST_RESPOND: state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // Outputs and RAM controls.
   always_comb begin
      busy      = 1'b1;
      rsp_valid = 1'b0;
      ram_we    = 1'b0;
      k_in      = k_ff;
      pend_in   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            k_in = '0;
         end
         ST_SEARCH: begin
            if (k_ff < n_ff) begin
               k_in    = k_ff + CNT_W'(1);
               pend_in = 1'b1;
            end
         end
         ST_WRITE:   ram_we    = 1'b1;
         ST_RESPOND: rsp_valid = 1'b1;
         default:    busy      = 1'b1;
      endcase
   end

   assign rsp_duplicate = dup_ff;
   assign ram_raddr     = base_ff + ADDR_W'(k_ff);
   assign ram_waddr     = base_ff + ADDR_W'(wp_ff[slot_ff]);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         k_ff     <= '0;
         n_ff     <= '0;
         pend_ff  <= 1'b0;
         dup_ff   <= 1'b0;
         for (int i = 0; i < CLIENTS; i++) begin
            wp_ff[i]     <= '0;
            full_ff[i]   <= 1'b0;
            active_ff[i] <= 1'b0;
         end
      end else begin
         state_ff <= state_in;
         k_ff     <= k_in;
         pend_ff  <= pend_in;
         if (accept) begin
            dup_ff <= 1'b0;
            if (!slot_bad) begin
               if (req_cmd == CMD_RELEASE) begin
                  active_ff[req_client_slot] <= 1'b0;
               end else if (!active_ff[req_client_slot]) begin
                  // First check on this slot starts an empty ring.
                  wp_ff[req_client_slot]   <= '0;
                  full_ff[req_client_slot] <= 1'b0;
               end
               n_ff <= full_ff[req_client_slot] ? CNT_W'(WINDOW)
                                                : CNT_W'(wp_ff[req_client_slot]);
            end
         end
         if (state_ff == ST_SEARCH && match) begin
            dup_ff <= 1'b1;
         end
         if (state_ff == ST_WRITE) begin
            active_ff[slot_ff] <= 1'b1;
            if (wp_ff[slot_ff] == IDX_W'(WINDOW - 1)) begin
               wp_ff[slot_ff]   <= '0;
               full_ff[slot_ff] <= 1'b1;
            end else begin
               wp_ff[slot_ff] <= wp_ff[slot_ff] + IDX_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff  <= req_cmd;
         slot_ff <= req_client_slot;
         id_ff   <= req_packet_id;
         base_ff <= ADDR_W'(req_client_slot) * ADDR_W'(WINDOW);
      end
   end

   dpf_ram #(
      .WIDTH (ID_W),
      .DEPTH (RING_DEPTH)
   ) u_ring (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (id_ff),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   `DPF_ASSERT(a_accept_busy, (start && !busy) |=> busy, "accepted item did not raise busy")
   `DPF_ASSERT(a_rsp_idle, rsp_valid |=> !busy, "block not idle after response")
   `DPF_ASSERT(a_search_bound, (state_ff == ST_SEARCH) |-> (k_ff <= n_ff), "search ran past ring fill")
   `DPF_ASSERT(a_wp_range, (state_ff == ST_WRITE) |-> (int'(wp_ff[slot_ff]) < WINDOW), "write pointer out of window")
   `DPF_NEVER(a_release_dup, rsp_valid && rsp_duplicate && cmd_ff == CMD_RELEASE, "release reported duplicate")

endmodule

// ===== test/duplicate_packet_id_filter_tb.sv =====
// ---------------------------------------------------------------------------
// duplicate_packet_id_filter_tb
// Drives check and release items through the start/busy port, predicts the
// duplicate flag of each item from a behavioral copy of the per-slot ID
// rings, and compares every response strobe against the oldest prediction.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module duplicate_packet_id_filter_tb;
   import dpf_pkg::*;

   localparam int ID_SPAN   = 1000001;   // sender IDs run 0..1000000 and wrap
   localparam int DRAIN_CYC = 60;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   logic              req_cmd = CMD_CHECK;
   logic [SLOT_W-1:0] req_client_slot = '0;
   logic [ID_W-1:0]   req_packet_id = '0;
   logic              rsp_valid;
   logic              rsp_duplicate;

   // Behavioral copy of the filter state.
   bit [ID_W-1:0] ring_ids   [CLIENTS][WINDOW];
   bit            ring_valid [CLIENTS][WINDOW];
   int unsigned   ring_wr_ptr[CLIENTS];
   bit            slot_live  [CLIENTS];

   bit          dup_expect_q[$];
   int          error_count = 0;
   bit          idle_on = 1'b1;
   int unsigned stream_next[CLIENTS];

   duplicate_packet_id_filter u_top (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_cmd         (req_cmd),
      .req_client_slot (req_client_slot),
      .req_packet_id   (req_packet_id),
      .rsp_valid       (rsp_valid),
      .rsp_duplicate   (rsp_duplicate)
   );

   always #2 clock = ~clock;

   function automatic void store_id(input int unsigned slot, input bit [ID_W-1:0] pid);
      int unsigned pos;
      pos = ring_wr_ptr[slot];
      if (pos >= WINDOW) pos = 0;
      ring_ids[slot][pos]   = pid;
      ring_valid[slot][pos] = 1'b1;
      pos++;
      if (pos >= WINDOW) pos = 0;
      ring_wr_ptr[slot] = pos;
   endfunction

   // Updates the state copy for one accepted item and returns its duplicate flag.
   function automatic bit filter_packet(input logic cmd, input logic [SLOT_W-1:0] slot_in,
                                        input logic [ID_W-1:0] pid);
      int unsigned slot;
      slot = 32'(slot_in);
      if (slot >= CLIENTS) return 1'b0;
      if (cmd == CMD_RELEASE) begin
         slot_live[slot] = 1'b0;
         return 1'b0;
      end
      if (slot_live[slot]) begin
         for (int k = 0; k < WINDOW; k++) begin
            if (ring_valid[slot][k] && ring_ids[slot][k] == pid) return 1'b1;
         end
         store_id(slot, pid);
      end else begin
         // A fresh session starts from an empty ring.
         for (int k = 0; k < WINDOW; k++) ring_valid[slot][k] = 1'b0;
         ring_wr_ptr[slot] = 0;
         store_id(slot, pid);
         slot_live[slot] = 1'b1;
      end
      return 1'b0;
   endfunction

   // Presents one item and returns at the edge where it is accepted.
   task automatic send_item(input logic cmd, input logic [SLOT_W-1:0] slot,
                            input logic [ID_W-1:0] pid);
      int gap;
      if (idle_on && $urandom_range(0, 99) < 13) begin
         gap = $urandom_range(1, 6);
         @(negedge clock);
         start <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      start           <= 1'b1;
      req_cmd         <= cmd;
      req_client_slot <= slot;
      req_packet_id   <= pid;
      do @(posedge clock); while (busy);
      dup_expect_q.push_back(filter_packet(cmd, slot, pid));
   endtask

   always @(posedge clock) begin
      bit want;
      if (!reset && rsp_valid) begin
         if (dup_expect_q.size() == 0) begin
            $display("%0t: response with no item outstanding, got duplicate %0b",
                     $time, rsp_duplicate);
            error_count++;
         end else begin
            want = dup_expect_q.pop_front();
            if (rsp_duplicate !== want) begin
               $display("%0t: duplicate mismatch, expected %0b, got %0b",
                        $time, want, rsp_duplicate);
               error_count++;
            end
         end
      end
   end

   task automatic test_id_extremes();
      send_item(CMD_CHECK, 4'd0, 20'd0);          // first check on an inactive slot
      send_item(CMD_CHECK, 4'd0, 20'd0);
      send_item(CMD_CHECK, 4'd0, 20'hFFFFF);      // above the sender's range
      send_item(CMD_CHECK, 4'd0, 20'hFFFFF);
      send_item(CMD_CHECK, 4'd0, 20'd1000000);
      send_item(CMD_CHECK, 4'd15, 20'd1000000);   // other slots keep their own ring
      send_item(CMD_CHECK, 4'd15, 20'd0);
      send_item(CMD_CHECK, 4'd15, 20'd0);
   endtask

   task automatic test_release();
      send_item(CMD_RELEASE, 4'd3, 20'd777);      // slot that was never active
      send_item(CMD_CHECK, 4'd3, 20'd12345);
      send_item(CMD_RELEASE, 4'd15, 20'd0);
      // The ring of a released slot is forgotten on its next check.
      send_item(CMD_CHECK, 4'd15, 20'd1000000);
      send_item(CMD_CHECK, 4'd15, 20'd0);
      send_item(CMD_CHECK, 4'd0, 20'd0);
      send_item(CMD_RELEASE, 4'd0, 20'd0);
      send_item(CMD_RELEASE, 4'd0, 20'hFFFFF);
      send_item(CMD_CHECK, 4'd0, 20'hFFFFF);
      send_item(CMD_CHECK, 4'd0, 20'd0);
      send_item(CMD_RELEASE, 4'd10, 20'hFFFFF);
   endtask

   task automatic test_window_wrap();
      int unsigned base;
      base = $urandom_range(0, 900000);
      for (int k = 0; k < WINDOW + 2; k++) send_item(CMD_CHECK, 4'd9, ID_W'(base + k));
      // The two oldest IDs have been overwritten, the rest are still held.
      send_item(CMD_CHECK, 4'd9, ID_W'(base));
      send_item(CMD_CHECK, 4'd9, ID_W'(base + 1));
      send_item(CMD_CHECK, 4'd9, ID_W'(base + WINDOW + 1));
      send_item(CMD_CHECK, 4'd9, ID_W'(base + 3));
      send_item(CMD_CHECK, 4'd9, ID_W'(base + 2));
   endtask

   // Mostly in-order packet streams with retransmits, plus releases and noise.
   task automatic test_packet_stream(input int count);
      int unsigned roll, back, pid, slot;
      for (int i = 0; i < count; i++) begin
         slot = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 3)
                                            : $urandom_range(0, CLIENTS - 1);
         roll = $urandom_range(0, 99);
         if (roll < 4) begin
            send_item(CMD_RELEASE, SLOT_W'(slot), ID_W'($urandom));
         end else if (roll < 12) begin
            send_item(CMD_CHECK, SLOT_W'(slot), ID_W'($urandom));
         end else if (roll < 42) begin
            back = $urandom_range(1, 60);
            pid  = (stream_next[slot] + ID_SPAN - back) % ID_SPAN;
            send_item(CMD_CHECK, SLOT_W'(slot), ID_W'(pid));
         end else begin
            pid = stream_next[slot];
            stream_next[slot] = (pid + 1) % ID_SPAN;
            send_item(CMD_CHECK, SLOT_W'(slot), ID_W'(pid));
         end
      end
   endtask

   initial begin
      for (int s = 0; s < CLIENTS; s++) begin
         // Some streams start close to the sender's wrap point.
         stream_next[s] = (s % 4 == 0) ? 1000000 - $urandom_range(0, 20)
                                       : $urandom_range(0, 999999);
      end
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_id_extremes();
      test_release();
      test_window_wrap();
      idle_on = 1'b1;
      test_packet_stream(250);
      idle_on = 1'b0;
      test_packet_stream(120);
      idle_on = 1'b1;
      test_packet_stream(130);

      @(negedge clock);
      start <= 1'b0;
      while (dup_expect_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYC) @(posedge clock);
      if (error_count == 0) begin
         $display("duplicate_packet_id_filter regression: pass");
      end else begin
         $display("duplicate_packet_id_filter regression: fail");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("duplicate_packet_id_filter regression: fail");
      $finish;
   end

endmodule
